>>> rtl/life_generation_step_macros.svh
// Assertion shorthands for the life generation block.
`ifndef LIFE_GENERATION_STEP_MACROS_SVH
`define LIFE_GENERATION_STEP_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define LGS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define LGS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Checks the cycle after reset is sampled; active during reset itself.
`define LGS_ASSERT_RESET(label, clk, rstn, cons, msg) \
    label: assert property (@(posedge clk) (!rstn) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lgs_pkg.sv
`timescale 1ns / 1ps

package lgs_pkg;

    localparam int ROW_W = 64;
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [ROW_W-1:0] row_cells;
        logic             first_row;
        logic             last_row;
    } row_in_t;

    typedef struct packed {
        logic [ROW_W-1:0] next_cells;
        logic             grid_done;
    } row_out_t;

    // Bits one cell shows its neighbours, already masked to the active width.
    typedef struct packed {
        logic up;
        logic mid;
        logic row;
    } cell_bits_t;

    // One queue slot: the results of one input row (one or two of them).
    typedef struct packed {
        logic [ROW_W-1:0] cells0;
        logic             done0;
        logic [ROW_W-1:0] cells1;
        logic             two;
    } q_entry_t;

endpackage

>>> rtl/lgs_cell.sv
`timescale 1ns / 1ps

module lgs_cell (
    input  logic              aclk,
    input  logic              shift_en,
    input  logic              active,
    input  logic              mid_ok,
    input  logic              row_bit,
    input  lgs_pkg::cell_bits_t left_nb,
    input  lgs_pkg::cell_bits_t right_nb,
    output lgs_pkg::cell_bits_t self_bits,
    output logic              res_mid,
    output logic              res_last
);

    logic up_reg, up_next;
    logic mid_reg, mid_next;
    logic [3:0] cnt_mid;
    logic [3:0] cnt_last;
    logic       mid_above_l, mid_above_r, mid_above_s;

    assign self_bits.up  = active & up_reg;
    assign self_bits.mid = active & mid_reg;
    assign self_bits.row = active & row_bit;

    // Neighbourhood of the pending row: above = upper, below = incoming row.
    assign cnt_mid = 4'(left_nb.up) + 4'(left_nb.mid) + 4'(left_nb.row)
                   + 4'(right_nb.up) + 4'(right_nb.mid) + 4'(right_nb.row)
                   + 4'(self_bits.up) + 4'(self_bits.row);

    // Bottom row: above = pending row (if any), below is all dead.
    assign mid_above_l = mid_ok & left_nb.mid;
    assign mid_above_r = mid_ok & right_nb.mid;
    assign mid_above_s = mid_ok & self_bits.mid;
    assign cnt_last = 4'(mid_above_l) + 4'(mid_above_r) + 4'(mid_above_s)
                    + 4'(left_nb.row) + 4'(right_nb.row);

    assign res_mid  = active & ((cnt_mid == 4'd3) | (self_bits.mid & (cnt_mid == 4'd2)));
    assign res_last = active & ((cnt_last == 4'd3) | (self_bits.row & (cnt_last == 4'd2)));

    always_comb begin
        up_next  = up_reg;
        mid_next = mid_reg;
        if (shift_en) begin
            up_next  = mid_ok & mid_reg;
            mid_next = row_bit;
        end
    end

    always_ff @(posedge aclk) begin
        up_reg  <= up_next;
        mid_reg <= mid_next;
    end

endmodule

>>> rtl/lgs_res_queue.sv
`timescale 1ns / 1ps

module lgs_res_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lgs_pkg::q_entry_t   push_entry,
    output logic                can_push,
    output logic                m_valid,
    input  logic                m_ready,
    output lgs_pkg::row_out_t   m_data
);

    localparam int PTR_W = $clog2(lgs_pkg::QDEPTH);
    localparam int CNT_W = $clog2(lgs_pkg::QDEPTH + 1);

    lgs_pkg::q_entry_t slot_reg [lgs_pkg::QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              sub_reg, sub_next;
    lgs_pkg::q_entry_t head;
    logic              pop;

    assign head     = slot_reg[rd_ptr_reg];
    assign can_push = (cnt_reg < CNT_W'(lgs_pkg::QDEPTH));
    assign m_valid  = (cnt_reg != '0);

    always_comb begin
        if (sub_reg) begin
            m_data.next_cells = head.cells1;
            m_data.grid_done  = 1'b1;
        end else begin
            m_data.next_cells = head.cells0;
            m_data.grid_done  = head.done0;
        end
    end

    // A two-result slot is left only after its second half goes out.
    assign pop = m_valid & m_ready & (sub_reg | ~head.two);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        sub_next    = sub_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(lgs_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (m_valid & m_ready) begin
            sub_next = ~pop;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(lgs_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            sub_reg    <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            sub_reg    <= sub_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/life_generation_step.sv
`timescale 1ns / 1ps
// life_generation_step: one generation of the game of life (B3/S23), row-streamed.
// Input channel (s_valid/s_ready/s_data): one grid row per transaction, top to
//   bottom; first_row opens a new grid, last_row closes it. Bit x is column x.
// Output channel (m_valid/m_ready/m_data): next state of one row per
//   transaction. Each row emits the result of the row before it; the bottom
//   row additionally emits its own result with grid_done set.
// cfg_wr_en/cfg_wr_data: active column count; columns at or above it (and at
//   or above MAX_COLUMNS) are dead and read back as zero. Write only when idle.
// Each result is registered in the result queue before it is presented.
// Throughput: one row per cycle while the queue has room. A bottom row with a
//   pending row above it yields two results, sent as two output transactions.
// The result queue has two row slots; s_ready drops only when both are full,
//   so a stalled receiver back-pressures the input once two rows have queued results.
// Reset: clears the queue and the open-grid flag, width returns to 64.
//   The row registers inside the cells need no reset: they are only read
//   while a grid is open.

module life_generation_step #(
    parameter int MAX_COLUMNS = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  lgs_pkg::row_in_t             s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output lgs_pkg::row_out_t            m_data,
    input  logic                         cfg_wr_en,
    input  logic [lgs_pkg::CFG_W-1:0]    cfg_wr_data
);

    logic [lgs_pkg::CFG_W-1:0] cols_reg, cols_next;
    logic                      mv_reg, mv_next;    // a pending row is held
    logic                      accept;
    logic                      mid_ok;             // pending row counts for this transaction
    logic [lgs_pkg::ROW_W-1:0] res_mid, res_last;
    lgs_pkg::q_entry_t         entry;
    logic                      q_push;

    lgs_pkg::cell_bits_t       cell_bits [MAX_COLUMNS];

    assign accept = s_valid & s_ready;
    // A first_row mark discards whatever grid was open.
    assign mid_ok = mv_reg & ~s_data.first_row;

    // Row of cells, one per column; each swaps its bits with both neighbours.
    for (genvar x = 0; x < MAX_COLUMNS; x++) begin : g_col
        lgs_pkg::cell_bits_t left_nb, right_nb;

        if (x == 0) begin : g_ledge
            assign left_nb = '0;
        end else begin : g_lnb
            assign left_nb = cell_bits[x-1];
        end

        if (x == MAX_COLUMNS - 1) begin : g_redge
            assign right_nb = '0;
        end else begin : g_rnb
            assign right_nb = cell_bits[x+1];
        end

        lgs_cell u_cell (
            .aclk      (aclk),
            .shift_en  (accept),
            .active    (lgs_pkg::CFG_W'(x) < cols_reg),
            .mid_ok    (mid_ok),
            .row_bit   (s_data.row_cells[x]),
            .left_nb   (left_nb),
            .right_nb  (right_nb),
            .self_bits (cell_bits[x]),
            .res_mid   (res_mid[x]),
            .res_last  (res_last[x])
        );
    end

    // Columns past the cell row are always dead.
    if (MAX_COLUMNS < lgs_pkg::ROW_W) begin : g_pad
        assign res_mid[lgs_pkg::ROW_W-1:MAX_COLUMNS]  = '0;
        assign res_last[lgs_pkg::ROW_W-1:MAX_COLUMNS] = '0;
    end

    // Pack the transaction's results: pending row first, bottom row second.
    always_comb begin
        entry.cells0 = mid_ok ? res_mid : res_last;
        entry.done0  = ~mid_ok;
        entry.cells1 = res_last;
        entry.two    = mid_ok & s_data.last_row;
    end

    assign q_push = accept & (mid_ok | s_data.last_row);

    lgs_res_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (entry),
        .can_push   (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    always_comb begin
        mv_next   = mv_reg;
        cols_next = cols_reg;
        if (accept) begin
            mv_next = ~s_data.last_row;
        end
        if (cfg_wr_en) begin
            cols_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg   <= 1'b0;
            cols_reg <= lgs_pkg::COLS_RESET;
        end else begin
            mv_reg   <= mv_next;
            cols_reg <= cols_next;
        end
    end

endmodule

>>> rtl/lgs_checker.sv
`timescale 1ns / 1ps
`include "life_generation_step_macros.svh"

module lgs_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  lgs_pkg::row_in_t          s_data,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  lgs_pkg::row_out_t         m_data,
    input  logic                      cfg_wr_en,
    input  logic [lgs_pkg::CFG_W-1:0] cfg_wr_data
);

    logic cfg_zero_seen;
    logic last_acc;
    logic m_stall;
    logic zero_idle;
    logic out_dead;

    assign cfg_zero_seen = cfg_wr_en & (cfg_wr_data == '0);
    assign last_acc      = s_valid & s_ready & s_data.last_row;
    assign m_stall       = m_valid & ~m_ready;
    assign zero_idle     = cfg_zero_seen & ~m_valid;
    assign out_dead      = ~m_valid | (m_data.next_cells == '0);

    `LGS_ASSERT_RESET(a_reset_empty, aclk, aresetn, !m_valid && s_ready, "busy after reset")
    `LGS_ASSERT_NEXT(a_last_result, aclk, aresetn, last_acc, m_valid, "no bottom result")
    `LGS_ASSERT_NEXT(a_hold, aclk, aresetn, m_stall, m_valid && $stable(m_data), "result moved")
    `LGS_ASSERT_NEXT(a_zero_dead, aclk, aresetn, zero_idle, out_dead, "live cell at width 0")

endmodule

bind life_generation_step lgs_checker u_lgs_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_data      (s_data),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_data      (m_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
);

>>> verif/life_generation_step_test.sv
`timescale 1ns / 1ps

module life_generation_step_test;

    // ------------------------------------------------------------------
    // Clock, reset and DUT connections
    // ------------------------------------------------------------------
    logic                      aclk        = 1'b0;
    logic                      aresetn     = 1'b0;
    logic                      s_valid     = 1'b0;
    logic                      s_ready;
    lgs_pkg::row_in_t          s_data      = '0;
    logic                      m_valid;
    logic                      m_ready     = 1'b0;
    lgs_pkg::row_out_t         m_data;
    logic                      cfg_wr_en   = 1'b0;
    logic [lgs_pkg::CFG_W-1:0] cfg_wr_data = '0;

    always #2 aclk = ~aclk;

    life_generation_step i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the two buffered rows and the width
    // ------------------------------------------------------------------
    logic [lgs_pkg::ROW_W-1:0] above_row    = '0;   // row above the pending one
    logic [lgs_pkg::ROW_W-1:0] pending_row  = '0;   // row waiting for its lower neighbour
    logic                      pending_open = 1'b0; // a grid is open with a pending row
    logic [lgs_pkg::CFG_W-1:0] active_cols  = lgs_pkg::COLS_RESET;

    lgs_pkg::row_out_t due_rows[$];                 // predicted results, oldest first

    // run bookkeeping
    int  mismatches   = 0;
    int  rows_sent    = 0;
    int  rows_checked = 0;
    int  stalls_seen  = 0;                 // cycles with s_valid high and s_ready low
    bit  send_jitter  = 1'b0;              // sender inserts random gaps
    bit  recv_jitter  = 1'b0;              // receiver inserts random stalls
    int  long_hold    = 0;                 // one-off long receiver stall, in cycles

    // Bits at or above the active width are dead; 0 kills everything,
    // anything from 64 upwards saturates to the full row.
    function automatic logic [lgs_pkg::ROW_W-1:0] width_mask(
            input logic [lgs_pkg::CFG_W-1:0] cols);
        if (cols >= lgs_pkg::ROW_W)
            return '1;
        return (64'd1 << cols) - 64'd1;
    endfunction

    // B3/S23 on one row given its neighbours above and below.
    function automatic logic [lgs_pkg::ROW_W-1:0] life_row(
            input logic [lgs_pkg::ROW_W-1:0] up,
            input logic [lgs_pkg::ROW_W-1:0] here,
            input logic [lgs_pkg::ROW_W-1:0] down);
        logic [lgs_pkg::ROW_W-1:0] m, a, h, b, nxt;
        int                        n;
        m   = width_mask(active_cols);
        a   = up & m;
        h   = here & m;
        b   = down & m;
        nxt = '0;
        for (int x = 0; x < lgs_pkg::ROW_W; x++) begin
            n = 0;
            n += a[x];
            n += b[x];
            if (x > 0) begin
                n += a[x-1];
                n += h[x-1];
                n += b[x-1];
            end
            if (x < lgs_pkg::ROW_W - 1) begin
                n += a[x+1];
                n += h[x+1];
                n += b[x+1];
            end
            nxt[x] = (n == 3) || (h[x] && n == 2);
        end
        return nxt & m;
    endfunction

    // Advance the grid state by one accepted row and queue what it produces.
    function automatic void predict_row(input lgs_pkg::row_in_t item);
        logic [lgs_pkg::ROW_W-1:0] up;
        lgs_pkg::row_out_t         r;
        if (item.first_row) begin
            // new grid: anything pending is dropped without a result
            above_row    = '0;
            pending_row  = '0;
            pending_open = 1'b0;
        end
        if (pending_open) begin
            r.next_cells = life_row(above_row, pending_row, item.row_cells);
            r.grid_done  = 1'b0;
            due_rows.push_back(r);
        end
        up = pending_open ? pending_row : '0;
        if (item.last_row) begin
            r.next_cells = life_row(up, item.row_cells, '0);
            r.grid_done  = 1'b1;
            due_rows.push_back(r);
            above_row    = '0;
            pending_row  = '0;
            pending_open = 1'b0;
        end else begin
            above_row    = up;
            pending_row  = item.row_cells;
            pending_open = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what,
                                   input logic [lgs_pkg::ROW_W-1:0] want,
                                   input logic [lgs_pkg::ROW_W-1:0] got);
        $display("ERROR %0t: %s expected %h got %h", $time, what, want, got);
        mismatches++;
    endtask

    // Outputs are sampled on the rising edge, before the DUT's registers move.
    always @(posedge aclk) begin
        lgs_pkg::row_out_t want;
        if (aresetn && s_valid && !s_ready)
            stalls_seen++;
        if (aresetn && m_valid && m_ready) begin
            if (due_rows.size() == 0) begin
                report_mismatch("unexpected result, next_cells", '0, m_data.next_cells);
            end else begin
                want = due_rows.pop_front();
                rows_checked++;
                if (m_data.next_cells !== want.next_cells)
                    report_mismatch("next_cells", want.next_cells, m_data.next_cells);
                if (m_data.grid_done !== want.grid_done)
                    report_mismatch("grid_done", want.grid_done, m_data.grid_done);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall before each result transaction, plus a one-off
    // long hold when a test asks for it. Drives on the falling edge.
    // ------------------------------------------------------------------
    initial begin : receiver
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall     = recv_jitter ? $urandom_range(0, 9) : 0;
            stall    += long_hold;
            long_hold = 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Sender side. All tasks are entered and left on a falling edge.
    // ------------------------------------------------------------------
    task automatic send_row(input logic [lgs_pkg::ROW_W-1:0] cells, input logic first,
                            input logic last);
        lgs_pkg::row_in_t item;
        int               gap;
        item.row_cells = cells;
        item.first_row = first;
        item.last_row  = last;
        gap = send_jitter ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        // valid stays up straight into the next row when there is no gap
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_row(item);
        rows_sent++;
        @(negedge aclk);
    endtask

    // Stop offering rows until every predicted result is in, then let the
    // pipeline settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (due_rows.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Register write; only ever called with the block drained.
    task automatic set_columns(input logic [lgs_pkg::CFG_W-1:0] cols);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cols;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        active_cols  = cols;
    endtask

    function automatic logic [lgs_pkg::ROW_W-1:0] random_cells();
        logic [lgs_pkg::ROW_W-1:0] r;
        int                        pick;
        r    = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 25)
            r &= {$urandom, $urandom};                             // sparse
        else if (pick < 40)
            r |= {$urandom, $urandom};                             // dense
        else if (pick < 55)
            r = 64'd7 << $urandom_range(0, lgs_pkg::ROW_W - 3);    // blinker segment
        else if (pick < 60)
            r = $urandom_range(0, 1) ? '1 : '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight after reset, a row with no first mark opens a grid anyway.
    task automatic test_unmarked_top_row();
        send_row(random_cells(), 1'b0, 1'b0);
        send_row('1, 1'b0, 1'b1);
    endtask

    // One-row grids and small known patterns, including both edge columns.
    task automatic test_known_patterns();
        send_row('1, 1'b1, 1'b1);
        send_row('0, 1'b1, 1'b1);
        // vertical blinker turns horizontal
        send_row(64'h8, 1'b1, 1'b0);
        send_row(64'h8, 1'b0, 1'b0);
        send_row(64'h8, 1'b0, 1'b1);
        // 2-wide columns hugging bit 0 and bit 63
        send_row(64'hC000_0000_0000_0003, 1'b1, 1'b0);
        send_row(64'hC000_0000_0000_0003, 1'b0, 1'b0);
        send_row('1, 1'b0, 1'b1);
    endtask

    // Width extremes: 0 kills all, above 64 saturates, 1 and 2 are narrow.
    task automatic test_width_limits();
        drain();
        set_columns(7'd0);
        send_row('1, 1'b1, 1'b1);
        drain();
        set_columns(7'd127);
        send_row('1, 1'b1, 1'b1);
        drain();
        set_columns(7'd1);
        send_row('1, 1'b1, 1'b0);
        send_row('1, 1'b0, 1'b1);
        drain();
        set_columns(7'd2);
        send_row('1, 1'b1, 1'b0);
        send_row('1, 1'b0, 1'b1);
        drain();
        set_columns(7'd65);
        send_row(64'hF0F0_0000_0000_0F0F, 1'b1, 1'b0);
        send_row('1, 1'b0, 1'b1);
        drain();
        set_columns(7'd64);
    endtask

    // First mark while a grid is open: pending row dropped, new grid begins.
    task automatic test_restart_open_grid();
        send_row(random_cells(), 1'b1, 1'b0);
        send_row(random_cells(), 1'b0, 1'b0);
        send_row(random_cells(), 1'b1, 1'b0);
        send_row(random_cells(), 1'b0, 1'b1);
    endtask

    // Sender pauses mid-grid until all results are in, width changes, grid
    // finishes under the new width.
    task automatic test_width_change_open_grid();
        send_row('1, 1'b1, 1'b0);
        send_row(random_cells(), 1'b0, 1'b0);
        drain();
        set_columns(7'd10);
        send_row('1, 1'b0, 1'b1);
        drain();
        set_columns(7'd64);
    endtask

    // Receiver holds off for a long stretch while rows keep coming, so the
    // result queue fills and s_ready must drop.
    task automatic test_output_stall();
        drain();
        send_jitter = 1'b0;
        recv_jitter = 1'b0;
        long_hold   = 60;
        send_row(random_cells(), 1'b1, 1'b0);
        for (int i = 0; i < 10; i++)
            send_row(random_cells(), 1'b0, 1'b0);
        send_row(random_cells(), 1'b0, 1'b1);
        drain();
    endtask

    // Mostly well-formed grids with random content, random heights and
    // widths; some grids lack the first mark, some get restarted part way.
    task automatic test_random_grids(input int target);
        int                        height, pick;
        logic                      first, last;
        logic [lgs_pkg::CFG_W-1:0] cols;
        while (rows_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                drain();
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    cols = 7'd0;
                else if (pick == 1)
                    cols = 7'd64;
                else if (pick == 2)
                    cols = $urandom_range(65, 127);
                else
                    cols = $urandom_range(1, 64);
                set_columns(cols);
            end
            // per-grid choice gives runs with and without idling
            send_jitter = $urandom_range(0, 3) != 0;
            recv_jitter = $urandom_range(0, 3) != 0;
            height = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                 : $urandom_range(1, 6);
            for (int r = 0; r < height; r++) begin
                if (r == 0)
                    first = $urandom_range(0, 9) != 0;
                else
                    first = $urandom_range(0, 19) == 0;   // restart noise
                last = (r == height - 1);
                // occasionally a grid is abandoned without its bottom row
                if (last && $urandom_range(0, 24) == 0)
                    last = 1'b0;
                send_row(random_cells(), first, last);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_unmarked_top_row();
        test_known_patterns();
        test_width_limits();
        test_restart_open_grid();
        test_width_change_open_grid();
        test_output_stall();
        test_random_grids(1350);

        drain();
        repeat (10) @(negedge aclk);

        $display("Run covered %0d rows in and %0d results out, widths 0 to 127,",
                 rows_sent, rows_checked);
        $display("restarts, a mid-grid width change and %0d input stall cycles.",
                 stalls_seen);
        if (mismatches == 0 && due_rows.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", due_rows.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/lgs_pkg.sv
rtl/lgs_cell.sv
rtl/lgs_res_queue.sv
rtl/life_generation_step.sv
rtl/lgs_checker.sv
verif/life_generation_step_test.sv
